>>> hw/rtl/fmpc_pkg.sv
// Shared types, constants and helper functions of the first-match rule classifier.
`default_nettype none

package fmpc_pkg;

	localparam int RULE_ENTRIES = 64;
	localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(RULE_ENTRIES + 1);

	localparam logic [1:0] OP_RESET    = 2'd0;
	localparam logic [1:0] OP_INSERT   = 2'd1;
	localparam logic [1:0] OP_CLASSIFY = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NOMATCH = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;
	localparam logic [1:0] STATUS_INVALID = 2'd3;

	localparam logic [7:0] PROTO_ICMP  = 8'd1;
	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_OTHER = 8'd255;
	localparam logic [7:0] PROTO_ANY   = 8'd143;

	localparam logic [15:0] PORT_ANY   = 16'd0;
	localparam logic [15:0] PORT_ABOVE = 16'd1023;
	localparam logic [5:0]  PREFIX_MAX = 6'd32;

	typedef struct packed {
		logic [1:0]  dir;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  ack;
	} pkt_t;

	// Address fields are stored already masked by their prefix.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_mask;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        action;
		logic [1:0]  ack;
		logic [7:0]  proto;
		logic [1:0]  dir;
	} rule_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [IDX_W-1:0] index;
		logic             verdict;
	} tok_t;

	// Top len bits set; a length of zero gives an empty mask.
	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		prefix_mask = ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic logic port_ok(input logic [15:0] rule_port,
	                                 input logic [15:0] pkt_port);
		if (rule_port == PORT_ANY) begin
			port_ok = 1'b1;
		end else if (rule_port == PORT_ABOVE) begin
			port_ok = pkt_port > PORT_ABOVE;
		end else begin
			port_ok = pkt_port == rule_port;
		end
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fmpc_cell.sv
// One rule cell: holds a single rule and passes the search token on to its neighbor.
`default_nettype none

module fmpc_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire fmpc_pkg::rule_t          wr_rule,
	input  wire logic                     active,
	input  wire logic [fmpc_pkg::IDX_W-1:0] idx,
	input  wire fmpc_pkg::pkt_t           pkt,
	input  wire fmpc_pkg::tok_t           tok_in,
	output fmpc_pkg::tok_t                tok_out
);

	fmpc_pkg::rule_t             rule_q;
	logic                        tok_valid_q;
	logic                        tok_found_q;
	logic [fmpc_pkg::IDX_W-1:0]  tok_index_q;
	logic                        tok_verdict_q;
	logic                        hit;
	logic                        l4;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
		end
	end

	always_comb begin
		l4  = (pkt.proto == fmpc_pkg::PROTO_TCP) || (pkt.proto == fmpc_pkg::PROTO_UDP);
		hit = active;
		if ((pkt.dir & rule_q.dir) == 2'b00) begin
			hit = 1'b0;
		end
		if ((rule_q.proto != fmpc_pkg::PROTO_ANY) && (rule_q.proto != pkt.proto)) begin
			hit = 1'b0;
		end
		if ((pkt.src_addr & rule_q.src_mask) != rule_q.src_addr) begin
			hit = 1'b0;
		end
		if ((pkt.dst_addr & rule_q.dst_mask) != rule_q.dst_addr) begin
			hit = 1'b0;
		end
		if (l4 && !(fmpc_pkg::port_ok(rule_q.sport, pkt.sport) &&
		            fmpc_pkg::port_ok(rule_q.dport, pkt.dport))) begin
			hit = 1'b0;
		end
		if ((pkt.proto == fmpc_pkg::PROTO_TCP) && ((pkt.ack & rule_q.ack) == 2'b00)) begin
			hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	// The first hit along the chain wins; later cells only forward it.
	always_ff @(posedge clk) begin
		if (tok_in.valid && !tok_in.found && hit) begin
			tok_found_q   <= 1'b1;
			tok_index_q   <= idx;
			tok_verdict_q <= rule_q.action;
		end else begin
			tok_found_q   <= tok_in.found;
			tok_index_q   <= tok_in.index;
			tok_verdict_q <= tok_in.verdict;
		end
	end

	always_comb begin
		tok_out.valid   = tok_valid_q;
		tok_out.found   = tok_found_q;
		tok_out.index   = tok_index_q;
		tok_out.verdict = tok_verdict_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/first_match_packet_rule_classifier_top.sv
// Top level of the first-match packet rule classifier: control, insert path and cell chain.
`default_nettype none

// The block keeps an ordered table of up to RULE_ENTRIES filter rules, one rule in
// each cell of a chain. The beat's tuser selects the operation: reset empties the
// table, insert checks a rule and appends it, classify looks for the first rule that
// matches the packet header. Reset and insert beats produce their result in the cycle
// after acceptance. A classify beat launches a search token that moves one cell per
// cycle down the chain, and its result is registered once the token leaves the last
// cell; the block takes one beat at a time, and during a search s_tready is low. The
// output register holds one result: a new beat is accepted while it is empty or in
// the cycle in which its waiting result is taken, as long as no search is running.
// Rules are held in flip-flops with no reset; only cells below the rule count ever
// take part in a search, so no clearing pass follows reset.

module first_match_packet_rule_classifier_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// direction[1:0], protocol[9:2], src_addr[41:10], dst_addr[73:42],
	// src_prefix_len[79:74], dst_prefix_len[85:80], source port[101:86],
	// destination port[117:102], ack_bits[119:118], rule_action[120],
	// zero fill up to 127
	input  wire logic [127:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// matched_index[5:0], verdict[6], rule_total[13:7], zero fill [15:14]
	output logic [15:0]       m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                          state_q;
	logic [fmpc_pkg::CNT_W-1:0]    count_q;
	fmpc_pkg::pkt_t                pkt_q;
	logic                          start_valid_q;
	fmpc_pkg::tok_t                start_tok;
	fmpc_pkg::tok_t                tok [fmpc_pkg::RULE_ENTRIES+1];
	logic [fmpc_pkg::RULE_ENTRIES:0] tok_v;

	logic       out_valid_q;
	logic [1:0] out_status_q;
	logic [5:0] out_index_q;
	logic       out_verdict_q;
	logic [6:0] out_total_q;

	logic [1:0]  op;
	logic [5:0]  src_len;
	logic [5:0]  dst_len;
	logic        act;
	fmpc_pkg::pkt_t  in_pkt;
	fmpc_pkg::rule_t new_rule;
	logic        accept;
	logic        rule_valid;
	logic        table_full;
	logic        do_insert;
	logic        scan_done;
	fmpc_pkg::tok_t last_tok;
	logic [1:0]  imm_status;
	logic [fmpc_pkg::CNT_W-1:0] next_count;

	// Unpack the incoming beat.
	always_comb begin
		op              = s_tuser;
		in_pkt.dir      = s_tdata[1:0];
		in_pkt.proto    = s_tdata[9:2];
		in_pkt.src_addr = s_tdata[41:10];
		in_pkt.dst_addr = s_tdata[73:42];
		src_len         = s_tdata[79:74];
		dst_len         = s_tdata[85:80];
		in_pkt.sport    = s_tdata[101:86];
		in_pkt.dport    = s_tdata[117:102];
		in_pkt.ack      = s_tdata[119:118];
		act             = s_tdata[120];
	end

	always_comb begin
		new_rule.src_mask = fmpc_pkg::prefix_mask(src_len);
		new_rule.dst_mask = fmpc_pkg::prefix_mask(dst_len);
		new_rule.src_addr = in_pkt.src_addr & new_rule.src_mask;
		new_rule.dst_addr = in_pkt.dst_addr & new_rule.dst_mask;
		new_rule.sport    = in_pkt.sport;
		new_rule.dport    = in_pkt.dport;
		new_rule.action   = act;
		new_rule.ack      = in_pkt.ack;
		new_rule.proto    = in_pkt.proto;
		new_rule.dir      = in_pkt.dir;
	end

	// A rule is rejected as invalid before the table-full check is made.
	assign rule_valid = (in_pkt.dir != 2'b00) && (in_pkt.ack != 2'b00) &&
	                    (src_len <= fmpc_pkg::PREFIX_MAX) &&
	                    (dst_len <= fmpc_pkg::PREFIX_MAX) &&
	                    (in_pkt.proto inside {fmpc_pkg::PROTO_ICMP, fmpc_pkg::PROTO_TCP,
	                                          fmpc_pkg::PROTO_UDP, fmpc_pkg::PROTO_OTHER,
	                                          fmpc_pkg::PROTO_ANY});
	assign table_full = count_q >= fmpc_pkg::CNT_W'(fmpc_pkg::RULE_ENTRIES);

	// One beat at a time; the output register must be free or freeing now.
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign do_insert = accept && (op == fmpc_pkg::OP_INSERT) && rule_valid && !table_full;

	always_comb begin
		next_count = count_q;
		imm_status = fmpc_pkg::STATUS_OK;
		case (op)
			fmpc_pkg::OP_RESET: begin
				next_count = '0;
			end
			fmpc_pkg::OP_INSERT: begin
				if (!rule_valid) begin
					imm_status = fmpc_pkg::STATUS_INVALID;
				end else if (table_full) begin
					imm_status = fmpc_pkg::STATUS_FULL;
				end else begin
					next_count = count_q + fmpc_pkg::CNT_W'(1);
				end
			end
			default: begin
				next_count = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	// The packet header stays put for the whole walk down the chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q <= in_pkt;
		end
	end

	// The search token enters the chain in the cycle after acceptance, once the
	// header register holds the packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_valid_q <= 1'b0;
		end else begin
			start_valid_q <= accept && (op == fmpc_pkg::OP_CLASSIFY);
		end
	end

	always_comb begin
		start_tok       = '0;
		start_tok.valid = start_valid_q;
	end

	assign tok[0] = start_tok;

	for (genvar k = 0; k < fmpc_pkg::RULE_ENTRIES; k++) begin : g_cell
		logic wr_en;
		logic active;

		assign wr_en  = do_insert &&
		                (count_q[fmpc_pkg::IDX_W-1:0] == fmpc_pkg::IDX_W'(k));
		assign active = fmpc_pkg::CNT_W'(k) < count_q;

		fmpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_rule (new_rule),
			.active  (active),
			.idx     (fmpc_pkg::IDX_W'(k)),
			.pkt     (pkt_q),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	for (genvar k = 0; k <= fmpc_pkg::RULE_ENTRIES; k++) begin : g_tokv
		assign tok_v[k] = tok[k].valid;
	end

	assign last_tok  = tok[fmpc_pkg::RULE_ENTRIES];
	assign scan_done = last_tok.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (op == fmpc_pkg::OP_CLASSIFY)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (op != fmpc_pkg::OP_CLASSIFY)) || scan_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op != fmpc_pkg::OP_CLASSIFY)) begin
			out_status_q  <= imm_status;
			out_index_q   <= '0;
			out_verdict_q <= 1'b0;
			out_total_q   <= 7'(next_count);
		end else if (scan_done) begin
			out_status_q  <= last_tok.found ? fmpc_pkg::STATUS_OK : fmpc_pkg::STATUS_NOMATCH;
			out_index_q   <= last_tok.found ? 6'(last_tok.index) : 6'd0;
			out_verdict_q <= last_tok.found && last_tok.verdict;
			out_total_q   <= 7'(count_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_total_q, out_verdict_q, out_index_q};

	// At most one search token is ever in the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_v) <= 1)
		else $error("more than one search token in the cell chain");

	// A token only moves while the block is searching.
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_v != '0) |-> (state_q == ST_SCAN))
		else $error("search token outside of a search");

	// No beat is taken while a search is running.
	a_no_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !s_tready)
		else $error("input ready during a search");

	// The rule count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fmpc_pkg::CNT_W'(fmpc_pkg::RULE_ENTRIES))
		else $error("rule count beyond table size");

	// A finished search lands in a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> !out_valid_q)
		else $error("search result would overwrite a pending result");

endmodule

`default_nettype wire
